// File: src/gb5_pkg.sv
// Shared constants, codes and types for the 5x5 Gaussian blur core.
// Depends on nothing; the files that use it refer to it by scoped names.
package gb5_pkg;

    // Default largest image width (line memory depth)
    localparam int MAX_WIDTH_DEF = 1024;

    // Register indexes on the configuration channel
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // Register reset values
    localparam logic [10:0] WIDTH_RESET  = 11'd640;
    localparam logic [15:0] HEIGHT_RESET = 16'd480;

    // Input item kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    // Depths of the command queue and the result queue
    localparam int CMD_DEPTH   = 4;
    localparam int CMD_CNT_W   = $clog2(CMD_DEPTH + 1);
    localparam int OUT_DEPTH   = 8;
    localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

    // Widest column address carried in a command (widths up to 8192)
    localparam int COL_W = 13;

    // Division by 159: floor(x * 52759 / 2^23) is exact for x below 2^23 / 73
    localparam logic [15:0] DIV_MUL   = 16'd52759;
    localparam int          DIV_SHIFT = 23;

    // One column pushed into the window and the work that goes with it
    typedef struct packed {
        logic [7:0]       pix;
        logic [COL_W-1:0] col;
        logic [4:0]       rmask;
        logic [4:0]       cmask;
        logic             emit;
        logic             row_end;
        logic             frame_end;
    } t_cmd;

    // One result beat
    typedef struct packed {
        logic [7:0] blurred_value;
        logic       row_end;
        logic       frame_end;
    } t_res;

endpackage

// File: src/gb5_if.sv
// Channel interfaces of the blur core: pixel input, result output, configuration.
// Depends on nothing.
interface gb5_pix_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] pixel_value;
    modport source (output valid, output kind, output pixel_value, input ready);
    modport sink   (input valid, input kind, input pixel_value, output ready);
endinterface

interface gb5_blur_if;
    logic       valid;
    logic       ready;
    logic [7:0] blurred_value;
    logic       row_end;
    logic       frame_end;
    modport source (output valid, output blurred_value, output row_end, output frame_end,
                    input ready);
    modport sink   (input valid, input blurred_value, input row_end, input frame_end,
                    output ready);
endinterface

interface gb5_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [15:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/gb5_fifo.sv
// Small first-in first-out queue in flip-flops, with an occupancy count.
// Depends on nothing; used for the command queue and the result queue.
module gb5_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [WIDTH-1:0]             i_data,
    input  logic                         i_pop,
    output logic [WIDTH-1:0]             o_data,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);
    localparam int PB = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_store [DEPTH];
    logic [PB-1:0]    r_head, r_tail;
    logic [CW-1:0]    r_count;

    assign o_data  = r_store[r_head];
    assign o_count = r_count;

    // Store the pushed beat
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_store[r_tail] <= i_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_tail <= (r_tail == PB'(DEPTH - 1)) ? '0 : r_tail + 1'b1;
            end
            if (i_pop) begin
                r_head <= (r_head == PB'(DEPTH - 1)) ? '0 : r_head + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule

// File: src/gb5_front.sv
// Front part: holds the size registers and frame counters, classifies each beat
// and issues window commands. Depends on gb5_pkg and the channel interfaces.
module gb5_front #(
    parameter int MAX_WIDTH = gb5_pkg::MAX_WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    gb5_cfg_if.sink        i_cfg,
    gb5_pix_if.sink        i_pix,
    input  logic           i_cmd_space,
    output logic           o_cmd_push,
    output gb5_pkg::t_cmd  o_cmd
);
    localparam int CB = $clog2(MAX_WIDTH);

    logic [10:0]   r_width;
    logic [15:0]   r_height;
    logic [CB-1:0] r_in_col, n_in_col;
    logic [16:0]   r_in_row, n_in_row;
    logic [CB-1:0] r_out_col, n_out_col;
    logic [15:0]   r_out_row, n_out_row;
    logic [12:0]   r_cnt, n_cnt;
    logic [12:0]   r_owed, n_owed;

    logic [10:0] w_eff;
    logic [15:0] h_eff;
    logic [12:0] lead;
    logic        draining, filler, started, accepted, cfg_wr;
    logic        is_pix, is_drain, emit, last_pix, in_col_last, out_col_last;
    logic [11:0] oc, w12;
    logic [4:0]  rmask, cmask;

    // Clamp the size registers
    always_comb begin
        if (r_width == '0) begin
            w_eff = 11'd1;
        end else if (32'(r_width) > MAX_WIDTH) begin
            w_eff = 11'(MAX_WIDTH);
        end else begin
            w_eff = r_width;
        end
        h_eff = (r_height == '0) ? 16'd1 : r_height;
        lead  = {1'b0, w_eff, 1'b0} + 13'd2;
    end

    // Classify the beat on offer
    assign cfg_wr      = i_cfg.valid && i_cfg.ready;
    assign i_cfg.ready = 1'b1;
    assign draining    = r_in_row >= {1'b0, h_eff};
    assign started     = r_cnt == lead;
    assign filler      = draining && (r_owed != '0) && !started;
    assign i_pix.ready = i_cmd_space && !filler;
    assign accepted    = i_pix.valid && i_pix.ready;
    assign is_pix      = accepted && (i_pix.kind == gb5_pkg::KIND_PIXEL) && !draining;
    assign is_drain    = accepted && (i_pix.kind == gb5_pkg::KIND_DRAIN) && draining
                         && (r_owed != '0);
    assign emit        = started && (is_pix || is_drain);
    assign o_cmd_push  = filler ? i_cmd_space : (is_pix || is_drain);

    assign w12          = 12'(w_eff);
    assign oc           = 12'(r_out_col);
    assign in_col_last  = 12'(r_in_col) == (w12 - 12'd1);
    assign out_col_last = oc == (w12 - 12'd1);
    assign last_pix     = is_pix && in_col_last && (r_in_row == {1'b0, h_eff - 16'd1});

    // Row validity of the pushed column, column validity of the output column
    always_comb begin
        for (int k = 0; k < 5; k++) begin
            rmask[k] = (r_in_row >= 17'(k)) && ((r_in_row - 17'(k)) < {1'b0, h_eff});
        end
        cmask[0] = oc >= 12'd2;
        cmask[1] = oc >= 12'd1;
        cmask[2] = 1'b1;
        cmask[3] = (oc + 12'd1) < w12;
        cmask[4] = (oc + 12'd2) < w12;
    end

    // Build the command
    always_comb begin
        o_cmd.pix       = is_pix ? i_pix.pixel_value : 8'd0;
        o_cmd.col       = gb5_pkg::COL_W'(r_in_col);
        o_cmd.rmask     = rmask;
        o_cmd.cmask     = cmask;
        o_cmd.emit      = emit;
        o_cmd.row_end   = out_col_last;
        o_cmd.frame_end = out_col_last && (r_out_row == h_eff - 16'd1);
    end

    // Next counter values
    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_cnt     = r_cnt;
        n_owed    = r_owed;
        if (o_cmd_push) begin
            if (in_col_last) begin
                n_in_col = '0;
                n_in_row = r_in_row + 17'd1;
            end else begin
                n_in_col = r_in_col + 1'b1;
            end
            if (!started) begin
                n_cnt = r_cnt + 13'd1;
            end
        end
        if (emit) begin
            if (out_col_last) begin
                n_out_col = '0;
                n_out_row = r_out_row + 16'd1;
            end else begin
                n_out_col = r_out_col + 1'b1;
            end
        end
        if (last_pix) begin
            n_owed = started ? lead : r_cnt + 13'd1;
        end
        if (is_drain) begin
            n_owed = r_owed - 13'd1;
        end
        // Restart the frame after the last owed output or on a register write
        if ((is_drain && r_owed == 13'd1) || cfg_wr) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
            n_cnt     = '0;
            n_owed    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= gb5_pkg::WIDTH_RESET;
            r_height  <= gb5_pkg::HEIGHT_RESET;
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_cnt     <= '0;
            r_owed    <= '0;
        end else begin
            if (cfg_wr) begin
                if (i_cfg.index == gb5_pkg::REG_WIDTH) begin
                    r_width <= i_cfg.data[10:0];
                end else begin
                    r_height <= i_cfg.data;
                end
            end
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_cnt     <= n_cnt;
            r_owed    <= n_owed;
        end
    end
endmodule

// File: src/gb5_back.sv
// Back part: line memory with four rows per column, 5x5 window, weighted sum
// and division by 159. Depends on gb5_pkg.
module gb5_back #(
    parameter int MAX_WIDTH = gb5_pkg::MAX_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  gb5_pkg::t_cmd                 i_cmd,
    output logic                          o_pop,
    input  logic [gb5_pkg::OUT_CNT_W-1:0] i_out_count,
    output logic                          o_push,
    output gb5_pkg::t_res                 o_res
);
    localparam int CB = $clog2(MAX_WIDTH);

    typedef logic [4:0][7:0] t_column;

    logic [31:0]   r_line_mem [MAX_WIDTH];
    logic [31:0]   r_rd;
    logic          r_s1_v;
    gb5_pkg::t_cmd r_s1;
    logic          r_fw_v;
    logic [CB-1:0] r_fw_addr;
    logic [31:0]   r_fw_data;
    t_column       r_win [5];
    logic          r_s2_v;
    logic [4:0]    r_s2_cmask;
    logic [1:0]    r_s2_flags;
    logic [13:0]   r_cs [5];
    logic          r_s3_v;
    logic [1:0]    r_s3_flags;
    logic [15:0]   r_sum;
    logic          r_s4_v;
    logic [1:0]    r_s4_flags;

    logic [4:0]    outstanding;
    logic [CB-1:0] s1_addr;
    logic [31:0]   word, wr_word;
    t_column       col_in;
    logic [13:0]   cs [5];
    logic [31:0]   prod;

    // Emitting commands issue only when the result queue can take all in flight
    always_comb begin
        outstanding = 5'(i_out_count) + 5'(r_s1_v && r_s1.emit) + 5'(r_s2_v)
                      + 5'(r_s3_v) + 5'(r_s4_v);
        o_pop = i_cmd_valid && (!i_cmd.emit || outstanding < 5'(gb5_pkg::OUT_DEPTH));
    end

    // Read the four stored rows of the column
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd <= r_line_mem[i_cmd.col[CB-1:0]];
            r_s1 <= i_cmd;
        end
    end

    // Forward a write to the same column made in the cycle before
    assign s1_addr = r_s1.col[CB-1:0];
    always_comb begin
        word    = (r_fw_v && r_fw_addr == s1_addr) ? r_fw_data : r_rd;
        wr_word = {word[23:0], r_s1.pix};
        col_in[0] = r_s1.rmask[0] ? r_s1.pix : 8'd0;
        for (int k = 1; k < 5; k++) begin
            col_in[k] = r_s1.rmask[k] ? word[8*(k-1) +: 8] : 8'd0;
        end
    end

    // Shift the rows down in memory and the column into the window
    always_ff @(posedge i_clk) begin
        if (r_s1_v) begin
            r_line_mem[s1_addr] <= wr_word;
            for (int j = 0; j < 4; j++) begin
                r_win[j] <= r_win[j+1];
            end
            r_win[4] <= col_in;
        end
        r_fw_addr  <= s1_addr;
        r_fw_data  <= wr_word;
        r_s2_cmask <= r_s1.cmask;
        r_s2_flags <= {r_s1.row_end, r_s1.frame_end};
    end

    // Weight each window column; the kernel is symmetric top to bottom
    always_comb begin
        for (int j = 0; j < 5; j++) begin
            logic [8:0] a, b;
            logic [7:0] c;
            a = 9'(r_win[j][0]) + 9'(r_win[j][4]);
            b = 9'(r_win[j][1]) + 9'(r_win[j][3]);
            c = r_win[j][2];
            if (j == 0 || j == 4) begin
                cs[j] = 14'({a, 1'b0}) + 14'({b, 2'b0}) + 14'(c) * 14'd5;
            end else if (j == 1 || j == 3) begin
                cs[j] = 14'({a, 2'b0}) + 14'(b) * 14'd9 + 14'(c) * 14'd12;
            end else begin
                cs[j] = 14'(a) * 14'd5 + 14'(b) * 14'd12 + 14'(c) * 14'd15;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 5; j++) begin
            r_cs[j] <= r_s2_cmask[j] ? cs[j] : 14'd0;
        end
        r_s3_flags <= r_s2_flags;
        r_sum      <= 16'(r_cs[0]) + 16'(r_cs[1]) + 16'(r_cs[2]) + 16'(r_cs[3])
                      + 16'(r_cs[4]);
        r_s4_flags <= r_s3_flags;
    end

    // Divide by 159 through a reciprocal multiply
    assign prod                = 32'(r_sum) * 32'(gb5_pkg::DIV_MUL);
    assign o_push              = r_s4_v;
    assign o_res.blurred_value = 8'(prod >> gb5_pkg::DIV_SHIFT);
    assign o_res.row_end       = r_s4_flags[1];
    assign o_res.frame_end     = r_s4_flags[0];

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_fw_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
        end else begin
            r_s1_v <= o_pop;
            r_fw_v <= r_s1_v;
            r_s2_v <= r_s1_v && r_s1.emit;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
        end
    end
endmodule

// File: src/gaussian_blur_5x5_core.sv
// Top level of the 5x5 Gaussian blur core (kernel sum 159).
// Depends on gb5_pkg, gb5_if, gb5_fifo, gb5_front and gb5_back.
//
// Usage:
//   i_cfg  : register writes (index 0 width, index 1 height); always ready.
//            A write restarts the frame; issue it only while the core is idle.
//   i_pix  : one beat per pixel in raster order (kind 0), then drain beats
//            (kind 1) to flush the last min(W*H, 2*W+2) outputs of the frame.
//   o_blur : blurred pixel with row-end and frame-end marks.
// Throughput is one beat per cycle while i_pix ready is high. The line memory
// holds one 32-bit word per column (four rows) with one read and one write port;
// a read of a column in the same cycle as a write to it is forwarded.
// An accepted beat's result passes the command queue, memory read, window shift,
// column weights and sum into the result queue before it is valid on o_blur.
// A frame shorter than 2*W+2 pixels holds i_pix ready low after its last pixel
// while the window is advanced internally.
// Reset restores 640x480 and clears all counters and queues; the line memory is
// not cleared, stale entries fall outside the frame and are masked.
// When o_blur stalls, results wait in an 8-deep queue; the back part stops
// issuing once every queue slot is spoken for, and i_pix ready drops when the
// 4-deep command queue fills.
module gaussian_blur_5x5_core #(
    parameter int MAX_WIDTH = gb5_pkg::MAX_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gb5_cfg_if.sink     i_cfg,
    gb5_pix_if.sink     i_pix,
    gb5_blur_if.source  o_blur
);
    logic                          cmd_push, cmd_pop;
    gb5_pkg::t_cmd                 cmd_in, cmd_out;
    logic [gb5_pkg::CMD_CNT_W-1:0] cmd_count;
    logic                          res_push, res_pop;
    gb5_pkg::t_res                 res_in, res_out;
    logic [gb5_pkg::OUT_CNT_W-1:0] res_count;

    // Classify beats and keep the frame counters
    gb5_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (i_cfg),
        .i_pix       (i_pix),
        .i_cmd_space (cmd_count < gb5_pkg::CMD_CNT_W'(gb5_pkg::CMD_DEPTH)),
        .o_cmd_push  (cmd_push),
        .o_cmd       (cmd_in)
    );

    // Command queue between the parts
    gb5_fifo #(.WIDTH($bits(gb5_pkg::t_cmd)), .DEPTH(gb5_pkg::CMD_DEPTH)) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out),
        .o_count (cmd_count)
    );

    // Window and arithmetic
    gb5_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_count != '0),
        .i_cmd       (cmd_out),
        .o_pop       (cmd_pop),
        .i_out_count (res_count),
        .o_push      (res_push),
        .o_res       (res_in)
    );

    // Result queue towards the receiver
    gb5_fifo #(.WIDTH($bits(gb5_pkg::t_res)), .DEPTH(gb5_pkg::OUT_DEPTH)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .i_pop   (res_pop),
        .o_data  (res_out),
        .o_count (res_count)
    );

    assign o_blur.valid         = res_count != '0;
    assign res_pop              = o_blur.valid && o_blur.ready;
    assign o_blur.blurred_value = res_out.blurred_value;
    assign o_blur.row_end       = res_out.row_end;
    assign o_blur.frame_end     = res_out.frame_end;
endmodule

// File: verif/gaussian_blur_5x5_core_tb.sv
// Testbench for gaussian_blur_5x5_core: a directed table, then random frames of many sizes.
// Results are checked against a behavioural blur predictor kept inside this file.
// Depends on gb5_pkg, gb5_if and the core itself.
`timescale 1ns / 1ps

module gaussian_blur_5x5_core_tb;

    localparam int LDEPTH     = 4 * gb5_pkg::MAX_WIDTH_DEF + 8;
    localparam int ITEM_GOAL  = 1850;
    localparam int CYCLE_LIMIT = 3_000_000;

    typedef enum int {ROW_CFG, ROW_BEAT} t_row_op;

    typedef struct {
        t_row_op       op;
        logic          kind;
        logic [7:0]    pix;
        logic          idx;
        logic [15:0]   data;
        bit            typed;
        gb5_pkg::t_res res;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    gb5_cfg_if  cfg_if ();
    gb5_pix_if  pix_if ();
    gb5_blur_if blur_if ();

    gaussian_blur_5x5_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if.sink),
        .i_pix   (pix_if.sink),
        .o_blur  (blur_if.source)
    );

    // Predictor state
    logic [7:0] line_mem [LDEPTH];
    int kern [5][5] = '{'{2, 4, 5, 4, 2}, '{4, 9, 12, 9, 4}, '{5, 12, 15, 12, 5},
                        '{4, 9, 12, 9, 4}, '{2, 4, 5, 4, 2}};
    int reg_w, reg_h;
    int in_col, in_row, out_col, out_row, owed;

    gb5_pkg::t_res blur_q [$];
    int   fails;
    int   items;
    int   send_idle, recv_stall;
    int   pressure_req;
    int   cycles;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int eff_w();
        if (reg_w == 0) return 1;
        if (reg_w > gb5_pkg::MAX_WIDTH_DEF) return gb5_pkg::MAX_WIDTH_DEF;
        return reg_w;
    endfunction

    function automatic int eff_h();
        return (reg_h == 0) ? 1 : reg_h;
    endfunction

    function automatic void restart_frame();
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
        owed    = 0;
    endfunction

    function automatic void apply_reg(logic idx, logic [15:0] data);
        if (idx == gb5_pkg::REG_WIDTH) reg_w = int'(data[10:0]);
        else reg_h = int'(data);
        restart_frame();
    endfunction

    // Weighted window sum around the next output position, then advance it
    function automatic gb5_pkg::t_res blur_next();
        gb5_pkg::t_res r;
        int w, h, rr, cc, sum;
        w   = eff_w();
        h   = eff_h();
        sum = 0;
        for (int dr = -2; dr <= 2; dr++) begin
            for (int dc = -2; dc <= 2; dc++) begin
                rr = out_row + dr;
                cc = out_col + dc;
                if (rr >= 0 && rr < h && cc >= 0 && cc < w)
                    sum += int'(line_mem[(rr * w + cc) % LDEPTH]) * kern[dr + 2][dc + 2];
            end
        end
        r.blurred_value = 8'(sum / 159);
        r.row_end       = (out_col == w - 1);
        r.frame_end     = (out_col == w - 1) && (out_row == h - 1);
        out_col++;
        if (out_col >= w) begin
            out_col = 0;
            out_row++;
        end
        return r;
    endfunction

    // Advance the predictor by one accepted beat; fired is low when nothing results
    function automatic void blur_step(logic kind, logic [7:0] pix, output bit fired,
                                      output bit used, output gb5_pkg::t_res r);
        int w, h, q, total;
        w     = eff_w();
        h     = eff_h();
        total = w * h;
        fired = 0;
        used  = 0;
        r     = '0;
        if (kind == gb5_pkg::KIND_DRAIN) begin
            if (in_row < h || owed == 0) return;
            used  = 1;
            fired = 1;
            r     = blur_next();
            owed--;
            if (owed == 0) restart_frame();
            return;
        end
        if (in_row >= h) return;
        used = 1;
        q = in_row * w + in_col;
        line_mem[q % LDEPTH] = pix;
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
        if (q >= 2 * w + 2) begin
            fired = 1;
            r     = blur_next();
        end
        if (q == total - 1) begin
            owed = total - (out_row * w + out_col);
            if (owed == 0) restart_frame();
        end
    endfunction

    // Offer one beat; sample the handshake at the falling edge, before the accepting edge
    task automatic send_beat(logic kind, logic [7:0] pix, bit typed,
                             gb5_pkg::t_res typed_res);
        bit   fired, used;
        gb5_pkg::t_res r;
        while ($urandom_range(99) < send_idle) begin
            pix_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_if.valid       <= 1'b1;
        pix_if.kind        <= kind;
        pix_if.pixel_value <= pix;
        @(negedge i_clk);
        while (!pix_if.ready) @(negedge i_clk);
        blur_step(kind, pix, fired, used, r);
        if (used) items++;
        if (typed) begin
            if (!fired) begin
                $error("blur: no result predicted where one was tabled");
                fails++;
            end
            blur_q.push_back(typed_res);
        end else if (fired) begin
            blur_q.push_back(r);
        end
        @(posedge i_clk);
    endtask

    // Write one register once the core has gone quiet
    task automatic write_reg(logic idx, logic [15:0] data);
        pix_if.valid <= 1'b0;
        @(posedge i_clk);
        while (blur_q.size() != 0) @(posedge i_clk);
        repeat (2 * eff_w() + 30) @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        @(negedge i_clk);
        while (!cfg_if.ready) @(negedge i_clk);
        apply_reg(idx, data);
        @(posedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [7:0] rand_pix();
        case ($urandom_range(9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // One full frame with some noise, then its drain
    task automatic run_frame();
        int n;
        gb5_pkg::t_res none;
        none = '0;
        n = eff_w() * eff_h();
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(19) == 0)
                send_beat(gb5_pkg::KIND_DRAIN, 8'($urandom), 0, none);
            send_beat(gb5_pkg::KIND_PIXEL, rand_pix(), 0, none);
        end
        while (owed != 0) begin
            if ($urandom_range(9) == 0)
                send_beat(gb5_pkg::KIND_PIXEL, 8'($urandom), 0, none);
            send_beat(gb5_pkg::KIND_DRAIN, 8'($urandom), 0, none);
        end
        if ($urandom_range(3) == 0) send_beat(gb5_pkg::KIND_DRAIN, 8'($urandom), 0, none);
    endtask

    // Result checker: compare each accepted result with the oldest expectation
    always @(negedge i_clk) begin
        gb5_pkg::t_res want;
        if (i_rst_n && blur_if.valid && blur_if.ready) begin
            if (blur_q.size() == 0) begin
                $error("blur: unexpected result %0d", blur_if.blurred_value);
                fails++;
            end else begin
                want = blur_q.pop_front();
                if (blur_if.blurred_value !== want.blurred_value) begin
                    $error("blurred_value: expected %0d, got %0d",
                           want.blurred_value, blur_if.blurred_value);
                    fails++;
                end
                if (blur_if.row_end !== want.row_end) begin
                    $error("row_end: expected %0d, got %0d", want.row_end, blur_if.row_end);
                    fails++;
                end
                if (blur_if.frame_end !== want.frame_end) begin
                    $error("frame_end: expected %0d, got %0d",
                           want.frame_end, blur_if.frame_end);
                    fails++;
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        int hold;
        hold = 0;
        blur_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (pressure_req != 0) begin
                hold = 400;
                pressure_req = 0;
            end
            if (hold > 0) begin
                hold--;
                blur_if.ready <= 1'b0;
            end else begin
                blur_if.ready <= ($urandom_range(99) >= recv_stall);
            end
        end
    end

    // Watchdog
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("** gaussian_blur_5x5_core: FAILED **");
                $finish;
            end
        end
    end

    // Stimulus
    initial begin
        t_row tbl [$];
        gb5_pkg::t_res none;
        int   phase, w, h, nfr;

        none = '0;
        fails = 0;
        items = 0;
        send_idle = 0;
        recv_stall = 0;
        pressure_req = 0;
        foreach (line_mem[i]) line_mem[i] = 8'h00;
        reg_w = int'(gb5_pkg::WIDTH_RESET);
        reg_h = int'(gb5_pkg::HEIGHT_RESET);
        restart_frame();

        i_rst_n            = 1'b0;
        pix_if.valid       = 1'b0;
        pix_if.kind        = gb5_pkg::KIND_PIXEL;
        pix_if.pixel_value = 8'h00;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = gb5_pkg::REG_WIDTH;
        cfg_if.data        = 16'h0000;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: single pixel frames, zero sizes, drain noise, narrow frames
        tbl = '{
            '{ROW_CFG,  gb5_pkg::KIND_PIXEL, 8'h00, gb5_pkg::REG_WIDTH,  16'd1,    0, none},
            '{ROW_CFG,  gb5_pkg::KIND_PIXEL, 8'h00, gb5_pkg::REG_HEIGHT, 16'd1,    0, none},
            '{ROW_BEAT, gb5_pkg::KIND_PIXEL, 8'hFF, gb5_pkg::REG_WIDTH,  16'd0,    0, none},
            '{ROW_BEAT, gb5_pkg::KIND_DRAIN, 8'h00, gb5_pkg::REG_WIDTH,  16'd0,    1,
              '{8'd24, 1'b1, 1'b1}},
            '{ROW_BEAT, gb5_pkg::KIND_DRAIN, 8'h00, gb5_pkg::REG_WIDTH,  16'd0,    0, none},
            '{ROW_CFG,  gb5_pkg::KIND_PIXEL, 8'h00, gb5_pkg::REG_WIDTH,  16'hF800, 0, none},
            '{ROW_CFG,  gb5_pkg::KIND_PIXEL, 8'h00, gb5_pkg::REG_HEIGHT, 16'd0,    0, none},
            '{ROW_BEAT, gb5_pkg::KIND_PIXEL, 8'hFF, gb5_pkg::REG_WIDTH,  16'd0,    0, none},
            '{ROW_BEAT, gb5_pkg::KIND_PIXEL, 8'h07, gb5_pkg::REG_WIDTH,  16'd0,    0, none},
            '{ROW_BEAT, gb5_pkg::KIND_DRAIN, 8'hFF, gb5_pkg::REG_WIDTH,  16'd0,    1,
              '{8'd24, 1'b1, 1'b1}},
            '{ROW_CFG,  gb5_pkg::KIND_PIXEL, 8'h00, gb5_pkg::REG_WIDTH,  16'd2,    0, none},
            '{ROW_CFG,  gb5_pkg::KIND_PIXEL, 8'h00, gb5_pkg::REG_HEIGHT, 16'hFFFF, 0, none},
            '{ROW_CFG,  gb5_pkg::KIND_PIXEL, 8'h00, gb5_pkg::REG_HEIGHT, 16'd1,    0, none},
            '{ROW_BEAT, gb5_pkg::KIND_PIXEL, 8'hFF, gb5_pkg::REG_WIDTH,  16'd0,    0, none},
            '{ROW_BEAT, gb5_pkg::KIND_PIXEL, 8'hFF, gb5_pkg::REG_WIDTH,  16'd0,    0, none},
            '{ROW_BEAT, gb5_pkg::KIND_DRAIN, 8'h00, gb5_pkg::REG_WIDTH,  16'd0,    1,
              '{8'd43, 1'b0, 1'b0}},
            '{ROW_BEAT, gb5_pkg::KIND_DRAIN, 8'h00, gb5_pkg::REG_WIDTH,  16'd0,    1,
              '{8'd43, 1'b1, 1'b1}},
            '{ROW_CFG,  gb5_pkg::KIND_PIXEL, 8'h00, gb5_pkg::REG_WIDTH,  16'd3,    0, none},
            '{ROW_CFG,  gb5_pkg::KIND_PIXEL, 8'h00, gb5_pkg::REG_HEIGHT, 16'd2,    0, none},
            '{ROW_BEAT, gb5_pkg::KIND_PIXEL, 8'h00, gb5_pkg::REG_WIDTH,  16'd0,    0, none},
            '{ROW_BEAT, gb5_pkg::KIND_PIXEL, 8'hFF, gb5_pkg::REG_WIDTH,  16'd0,    0, none},
            '{ROW_BEAT, gb5_pkg::KIND_PIXEL, 8'h80, gb5_pkg::REG_WIDTH,  16'd0,    0, none},
            '{ROW_BEAT, gb5_pkg::KIND_PIXEL, 8'h7F, gb5_pkg::REG_WIDTH,  16'd0,    0, none},
            '{ROW_BEAT, gb5_pkg::KIND_PIXEL, 8'hFF, gb5_pkg::REG_WIDTH,  16'd0,    0, none},
            '{ROW_BEAT, gb5_pkg::KIND_PIXEL, 8'h01, gb5_pkg::REG_WIDTH,  16'd0,    0, none}
        };
        foreach (tbl[i]) begin
            if (tbl[i].op == ROW_CFG) write_reg(tbl[i].idx, tbl[i].data);
            else send_beat(tbl[i].kind, tbl[i].pix, tbl[i].typed, tbl[i].res);
        end
        while (owed != 0) send_beat(gb5_pkg::KIND_DRAIN, 8'h00, 0, none);

        // Random phases: sizes mostly small, a few wider ones and zero sizes
        phase = 0;
        while (items < ITEM_GOAL) begin
            case (phase % 5)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 68; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 68; end
                3: begin send_idle = 38; recv_stall = 38; end
                default: begin send_idle = $urandom_range(20); recv_stall = 0; end
            endcase
            case ($urandom_range(19))
                0: begin w = $urandom_range(120, 81); h = $urandom_range(2, 1); end
                1: begin w = 0; h = $urandom_range(6); end
                2, 3, 4: begin w = $urandom_range(80, 13); h = $urandom_range(6, 1); end
                default: begin w = $urandom_range(12, 1); h = $urandom_range(8, 1); end
            endcase
            // Give the long hold-off a frame big enough to fill every queue
            if (phase == 2) begin
                w = 16;
                h = 4;
            end
            if ($urandom_range(1) == 0) begin
                write_reg(gb5_pkg::REG_WIDTH,  {5'($urandom), 11'(w)});
                write_reg(gb5_pkg::REG_HEIGHT, 16'(h));
            end else begin
                write_reg(gb5_pkg::REG_HEIGHT, 16'(h));
                write_reg(gb5_pkg::REG_WIDTH,  {5'($urandom), 11'(w)});
            end
            if (phase == 2) pressure_req = 1;
            nfr = $urandom_range(3, 1);
            for (int f = 0; f < nfr && items < ITEM_GOAL; f++) run_frame();
            phase++;
        end

        // Let the last results come out
        pix_if.valid <= 1'b0;
        while (blur_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fails == 0) begin
            $display("** gaussian_blur_5x5_core: PASSED **");
        end else begin
            $display("** gaussian_blur_5x5_core: FAILED **");
        end
        $finish;
    end

endmodule
